/* rtl/core/stkrc_pkg.sv */
// ----------------------------------------------------------------------------
// stkrc_pkg
// Types and constants shared by the stack block and its storage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stkrc_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REPLACE = 2'd2,
    OP_CHECK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_RESP
  } state_e;

  // Value returned by a pop from an empty stack.
  localparam logic [WORD_W-1:0] RESULT_EMPTY = '1;

  typedef struct packed {
    op_e                      opcode;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] old_value;
  } stkrc_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    status_e                  status;
  } stkrc_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/stkrc_mem.sv */
// ----------------------------------------------------------------------------
// stkrc_mem
// Stack storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stkrc_mem import stkrc_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stack_with_replace_and_order_check.sv */
// ----------------------------------------------------------------------------
// stack_with_replace_and_order_check
// Bounded LIFO stack with replace-all-matches and strict order check.
// ----------------------------------------------------------------------------
// Push and empty pop go from accept straight to S_RESP; a pop passes S_POP.
// Replace and order check walk the stored entries in S_WALK, then S_RESP; the
// walk issues one storage read per cycle through the single read port and
// compares it in the next cycle. A new request is taken only once the block
// has loaded the response into its output register and is back in S_IDLE.
// Reset clears the entry count and the handshake state; the storage itself
// is not cleared and is only read below the entry count.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_replace_and_order_check import stkrc_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire stkrc_req_t in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output stkrc_rsp_t      out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;
  stkrc_rsp_t        out_q, out_d;
  logic              pend_q, pend_d;

  logic              is_check_q, is_check_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [WORD_W-1:0] old_q, old_d;
  logic [CW-1:0]     left_q, left_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic              has_prev_q, has_prev_d;
  logic [WORD_W-1:0] prev_q, prev_d;
  logic              ok_q, ok_d;
  logic [WORD_W-1:0] res_q, res_d;
  status_e           stat_q, stat_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic              accept;
  logic              issue;
  logic [CW-1:0]     count_m1;

  stkrc_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign count_m1    = count_q - CW'(1);
  assign issue       = (left_q != '0);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pend_d      = 1'b0;
    is_check_d  = is_check_q;
    val_d       = val_q;
    old_d       = old_q;
    left_d      = left_q;
    addr_d      = addr_q;
    pend_addr_d = pend_addr_q;
    has_prev_d  = has_prev_q;
    prev_d      = prev_q;
    ok_d        = ok_q;
    res_d       = res_q;
    stat_d      = stat_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_wdata   = in_data_i.value;
    mem_re      = 1'b0;
    mem_raddr   = count_m1[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d      = in_data_i.value;
          old_d      = in_data_i.old_value;
          is_check_d = (in_data_i.opcode == OP_CHECK);
          res_d      = '0;
          stat_d     = STAT_OK;
          case (in_data_i.opcode)
            OP_PUSH: begin
              if (count_q >= CW'(DEPTH)) begin
                stat_d = STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
              state_d = S_RESP;
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_d   = RESULT_EMPTY;
                stat_d  = STAT_EMPTY;
                state_d = S_RESP;
              end else begin
                mem_re  = 1'b1;
                state_d = S_POP;
              end
            end
            default: begin
              // Replace walks upward from the bottom, order check downward
              // from the top.
              left_d     = count_q;
              addr_d     = (in_data_i.opcode == OP_CHECK) ? count_m1[AW-1:0] : '0;
              has_prev_d = 1'b0;
              ok_d       = 1'b1;
              state_d    = S_WALK;
            end
          endcase
        end
      end

      S_POP: begin
        res_d   = mem_rdata;
        count_d = count_m1;
        state_d = S_RESP;
      end

      S_WALK: begin
        mem_re      = issue;
        mem_raddr   = addr_q;
        pend_d      = issue;
        pend_addr_d = addr_q;
        if (issue) begin
          left_d = left_q - CW'(1);
          addr_d = is_check_q ? addr_q - AW'(1) : addr_q + AW'(1);
        end
        if (pend_q) begin
          if (is_check_q) begin
            // The entry read earlier sits above this one and must be smaller.
            if (has_prev_q && ($signed(prev_q) >= $signed(mem_rdata))) begin
              ok_d = 1'b0;
            end
            prev_d     = mem_rdata;
            has_prev_d = 1'b1;
          end else if (mem_rdata == old_q) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_q;
            mem_wdata = val_q;
          end
        end
        if (!issue && !pend_q) begin
          res_d   = is_check_q ? {{(WORD_W-1){1'b0}}, ok_q} : '0;
          stat_d  = STAT_OK;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.result_value = res_q;
          out_d.status       = stat_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    is_check_q  <= is_check_d;
    val_q       <= val_d;
    old_q       <= old_d;
    left_q      <= left_d;
    addr_q      <= addr_d;
    pend_addr_q <= pend_addr_d;
    has_prev_q  <= has_prev_d;
    prev_q      <= prev_d;
    ok_q        <= ok_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
  end

endmodule

`default_nettype wire
